// ----- rtl/core/smm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, sizes and index helpers for the square matrix multiply core.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int DIM    = 64;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int K_W    = $clog2(DIM);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // row, col, a_value, b_value = 76 bits, padded to 80
  localparam int IN_TDATA_W  = 80;
  // out_row, out_col, product_value = 44 bits, padded to 48
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_DOT  = 2'd1,
    OP_ZERO = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [DATA_W-1:0]  a_value;
    logic [DATA_W-1:0]  b_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic in_range(input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col);
    return (32'(row) < 32'(DIM)) && (32'(col) < 32'(DIM));
  endfunction

  // row-major cell address; only called with indices below DIM
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(32'(row) * 32'(DIM) + 32'(col));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/smm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/smm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smm_front
// Input side: takes items, sorts them into load / dot / zero operations,
// drops out-of-range loads and queues the rest for the back end.
// ----------------------------------------------------------------------------
module smm_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_valid_i,
  output logic                                  s_ready_o,
  input  wire logic                             s_kind_i,
  input  wire logic [smm_pkg::IN_TDATA_W-1:0]   s_data_i,
  output smm_pkg::q_head_t                      q_head_o,
  input  wire logic                             q_pop_i
);

  smm_pkg::item_t                  slots_q [smm_pkg::QDEPTH];
  logic [smm_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [smm_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [smm_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  smm_pkg::item_t                  in_item;
  logic                            keep;
  logic                            push;

  always_comb begin
    in_item.row     = s_data_i[smm_pkg::IDX_W-1:0];
    in_item.col     = s_data_i[2*smm_pkg::IDX_W-1:smm_pkg::IDX_W];
    in_item.a_value = s_data_i[2*smm_pkg::IDX_W+smm_pkg::DATA_W-1:2*smm_pkg::IDX_W];
    in_item.b_value = s_data_i[2*smm_pkg::IDX_W+2*smm_pkg::DATA_W-1:
                               2*smm_pkg::IDX_W+smm_pkg::DATA_W];
    if (!s_kind_i) begin
      in_item.op = smm_pkg::OP_LOAD;
    end else if (smm_pkg::in_range(in_item.row, in_item.col)) begin
      in_item.op = smm_pkg::OP_DOT;
    end else begin
      in_item.op = smm_pkg::OP_ZERO;
    end
    // out-of-range loads change nothing and never reach the back end
    keep = s_kind_i || smm_pkg::in_range(in_item.row, in_item.col);
  end

  assign s_ready_o = (cnt_q != smm_pkg::QCNT_W'(smm_pkg::QDEPTH));
  assign push      = s_valid_i && s_ready_o && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == smm_pkg::QPTR_W'(smm_pkg::QDEPTH - 1)) ?
                 '0 : wr_ptr_q + smm_pkg::QPTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == smm_pkg::QPTR_W'(smm_pkg::QDEPTH - 1)) ?
                 '0 : rd_ptr_q + smm_pkg::QPTR_W'(1);
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + smm_pkg::QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - smm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_item;
    end
  end

  assign q_head_o.valid = (cnt_q != '0);
  assign q_head_o.item  = slots_q[rd_ptr_q];

endmodule
`default_nettype wire

// ----- rtl/core/smm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smm_back
// Execution side: owns both matrix RAMs, writes load items, runs one
// multiply-accumulate per cycle for a dot item and holds the result register.
// ----------------------------------------------------------------------------
module smm_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire smm_pkg::q_head_t                  q_head_i,
  output logic                                   q_pop_o,
  output logic                                   m_valid_o,
  input  wire logic                              m_ready_i,
  output logic [smm_pkg::OUT_TDATA_W-1:0]        m_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [smm_pkg::K_W-1:0]         k_q, k_d;
  logic [smm_pkg::ADDR_W-1:0]      a_addr_q, a_addr_d;
  logic [smm_pkg::ADDR_W-1:0]      b_addr_q, b_addr_d;
  logic [smm_pkg::IDX_W-1:0]       row_q, row_d;
  logic [smm_pkg::IDX_W-1:0]       col_q, col_d;
  logic [smm_pkg::DATA_W-1:0]      acc_q, acc_d;
  logic [smm_pkg::DATA_W-1:0]      prod_q;
  logic                            rd_vld_q, rd_vld_d;
  logic                            rd_last_q, rd_last_d;
  logic                            prod_vld_q, prod_last_q;

  logic                            out_vld_q, out_vld_d;
  logic [smm_pkg::IDX_W-1:0]       out_row_q, out_col_q;
  logic [smm_pkg::DATA_W-1:0]      out_val_q;
  logic                            out_load;
  logic                            out_free;

  logic                            we;
  logic [smm_pkg::ADDR_W-1:0]      waddr;
  logic [smm_pkg::DATA_W-1:0]      a_rdata, b_rdata;

  assign out_free = !out_vld_q || m_ready_i;
  assign waddr    = smm_pkg::cell_addr(q_head_i.item.row, q_head_i.item.col);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    a_addr_d  = a_addr_q;
    b_addr_d  = b_addr_q;
    row_d     = row_q;
    col_d     = col_q;
    acc_d     = prod_vld_q ? acc_q + prod_q : acc_q;
    rd_vld_d  = 1'b0;
    rd_last_d = 1'b0;
    q_pop_o   = 1'b0;
    we        = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_head_i.valid) begin
          q_pop_o = 1'b1;
          row_d   = q_head_i.item.row;
          col_d   = q_head_i.item.col;
          acc_d   = '0;
          case (q_head_i.item.op)
            smm_pkg::OP_LOAD: we = 1'b1;
            smm_pkg::OP_DOT: begin
              k_d      = '0;
              a_addr_d = smm_pkg::cell_addr(q_head_i.item.row, '0);
              b_addr_d = smm_pkg::cell_addr('0, q_head_i.item.col);
              state_d  = ST_RUN;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RUN: begin
        // one read of A[row][k] and B[k][col] per cycle
        rd_vld_d  = 1'b1;
        rd_last_d = (k_q == smm_pkg::K_W'(smm_pkg::DIM - 1));
        k_d       = k_q + smm_pkg::K_W'(1);
        a_addr_d  = a_addr_q + smm_pkg::ADDR_W'(1);
        b_addr_d  = b_addr_q + smm_pkg::ADDR_W'(smm_pkg::DIM);
        if (rd_last_d) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_vld_d = out_load || (out_vld_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      prod_vld_q  <= rd_vld_q;
      prod_last_q <= rd_last_q;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    row_q    <= row_d;
    col_q    <= col_d;
    acc_q    <= acc_d;
    // low word of the product is all that the wrapped sum needs
    prod_q   <= smm_pkg::DATA_W'(a_rdata * b_rdata);
    if (out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_val_q <= acc_q;
    end
  end

  smm_ram #(
    .WIDTH (smm_pkg::DATA_W),
    .DEPTH (smm_pkg::CELLS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_head_i.item.a_value),
    .raddr_i (a_addr_q),
    .rdata_o (a_rdata)
  );

  smm_ram #(
    .WIDTH (smm_pkg::DATA_W),
    .DEPTH (smm_pkg::CELLS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_head_i.item.b_value),
    .raddr_i (b_addr_q),
    .rdata_o (b_rdata)
  );

  assign m_valid_o = out_vld_q;
  assign m_data_o  = {{(smm_pkg::OUT_TDATA_W - 2*smm_pkg::IDX_W - smm_pkg::DATA_W){1'b0}},
                      out_val_q, out_col_q, out_row_q};

endmodule
`default_nettype wire

// ----- rtl/core/square_matrix_multiply_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_multiply_core
// Stores two DIM x DIM signed 32-bit matrices and returns single elements of
// their product on request.
//
//   channel  dir  tdata                                  tuser
//   s_axis   in   row, col, a_value, b_value (80 bits)   kind
//   m_axis   out  out_row, out_col, product_value (48)   -
//
// A load item is written to both matrix RAMs from idle; a compute item runs
// one multiply-accumulate per cycle through the single read port of each
// matrix RAM and holds the back end until its result is loaded. A two-item
// queue between input and back end and a result register for the finished
// element let up to three more compute items in while m_axis stalls. Matrix
// contents are not cleared by reset; the queue, sequencer and result valid are.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [5:0] row, [11:6] col, [43:12] a_value, [75:44] b_value, [79:76] zero
  input  wire logic [smm_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] kind: 0 load, 1 compute
  input  wire logic                             s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [5:0] out_row, [11:6] out_col, [43:12] product_value, [47:44] zero
  output logic [smm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);

  smm_pkg::q_head_t q_head;
  logic             q_pop;

  smm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_kind_i  (s_axis_tuser_i),
    .s_data_i  (s_axis_tdata_i),
    .q_head_o  (q_head),
    .q_pop_i   (q_pop)
  );

  smm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

`ifndef SYNTH
  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // input stalls only when the queue holds items
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_head.valid)
    else $error("input stalled with empty queue");

  // a popped compute item keeps the back end busy, so no pop follows at once
  a_dot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_head.item.op != smm_pkg::OP_LOAD) |=> !q_pop)
    else $error("pop while compute in progress");
`endif

endmodule
`default_nettype wire
